### src/frq_pkg.sv
`default_nettype none
package frq_pkg;

  localparam int SLOTS      = 16;
  localparam int FRAME_BITS = 64;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = 8;
  localparam int SIZE_W     = 4;
  localparam int BYTES_W    = 8;
  localparam int OP_W       = 2;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  localparam logic [OP_W-1:0] OP_SEND   = 2'd0;
  localparam logic [OP_W-1:0] OP_RECV   = 2'd1;
  localparam logic [OP_W-1:0] OP_REPEAT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FAIL    = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOFRAME = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } cnt_req_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [FRAME_BITS-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } frm_req_t;

  // keep the low bytes*8 bits, capped at the frame width
  function automatic logic [FRAME_BITS-1:0] size_mask(input logic [SIZE_W-1:0] bytes);
    logic [FRAME_BITS-1:0] m;
    logic [SIZE_W+2:0]     bits;
    bits = {bytes, 3'b000};
    for (int i = 0; i < FRAME_BITS; i++) begin
      m[i] = (32'(i) < 32'(bits));
    end
    return m;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    return (idx == LAST_SLOT) ? '0 : idx + IDX_W'(1);
  endfunction

endpackage
`default_nettype wire

### src/frq_count_mem.sv
`default_nettype none
module frq_count_mem (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire frq_pkg::cnt_req_t       req,
  output logic [frq_pkg::CNT_W-1:0]    rdata
);

  logic [frq_pkg::CNT_W-1:0] mem [frq_pkg::SLOTS];
  logic [frq_pkg::SLOTS-1:0] valid;
  logic [frq_pkg::CNT_W-1:0] rd_q;
  logic                      rd_valid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_q <= mem[req.raddr];
    end
  end

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rd_valid <= valid[req.raddr];
      end
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule
`default_nettype wire

### src/frq_frame_mem.sv
`default_nettype none
module frq_frame_mem (
  input  wire logic                       clk,
  input  wire frq_pkg::frm_req_t          req,
  output logic [frq_pkg::FRAME_BITS-1:0]  rdata
);

  logic [frq_pkg::FRAME_BITS-1:0] mem [frq_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

### src/frame_ring_queue_with_repeat_top.sv
`default_nettype none
// Ring queue of frame slots with per-slot repeat counts. Each operation has an accept
// cycle and an evaluation state: the accept cycle issues reads of the slot count and frame
// memories (registered reads), the evaluation state evaluates the operation, writes the
// memories back and loads the result register, and no new item is taken before then. Because an
// item's write-back finishes before the next item's read is issued, no forwarding
// is needed. The result register lets the next item be accepted while a result
// still waits; the evaluation holds only while that register is occupied and out_stall is high.
// frame_bytes_in_use (cfg_data) resets to 8 and is always ready for a write.
module frame_ring_queue_with_repeat_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [frq_pkg::OP_W-1:0]       operation,
  input  wire logic [frq_pkg::FRAME_BITS-1:0] frame_word,
  input  wire logic [frq_pkg::BYTES_W-1:0]    frame_bytes,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          status,
  output logic [frq_pkg::FRAME_BITS-1:0]      frame_out,
  output logic [frq_pkg::SIZE_W-1:0]          size_out,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [frq_pkg::SIZE_W-1:0]     cfg_data
);

  frq_pkg::state_t                 state, state_next;
  logic [frq_pkg::SIZE_W-1:0]      cfg_size;
  logic [frq_pkg::IDX_W-1:0]       head, head_next;
  logic [frq_pkg::IDX_W-1:0]       tail, tail_next;
  logic                            empty, empty_next;
  logic                            any_sent, any_sent_next;

  logic [frq_pkg::OP_W-1:0]        op_q;
  logic [frq_pkg::FRAME_BITS-1:0]  word_q;
  logic [frq_pkg::BYTES_W-1:0]     bytes_q;

  frq_pkg::cnt_req_t               cnt_req;
  frq_pkg::frm_req_t               frm_req;
  logic [frq_pkg::CNT_W-1:0]       cnt_rd;
  logic [frq_pkg::FRAME_BITS-1:0]  frm_rd;

  frq_pkg::status_t                res_status;
  logic [frq_pkg::FRAME_BITS-1:0]  res_frame;
  logic [frq_pkg::SIZE_W-1:0]      res_size;

  logic                            in_xfer;
  logic                            exec_go;
  logic [frq_pkg::FRAME_BITS-1:0]  mask;
  logic [frq_pkg::IDX_W-1:0]       send_slot;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign exec_go   = (state == frq_pkg::S_EXEC) && (!out_valid || !out_stall);
  assign mask      = frq_pkg::size_mask(cfg_size);

  frq_count_mem u_cnt (
    .clk   (clk),
    .rst   (rst),
    .req   (cnt_req),
    .rdata (cnt_rd)
  );

  frq_frame_mem u_frm (
    .clk   (clk),
    .req   (frm_req),
    .rdata (frm_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      frq_pkg::S_IDLE: begin
        if (in_xfer) state_next = frq_pkg::S_EXEC;
      end
      frq_pkg::S_EXEC: begin
        if (exec_go) state_next = frq_pkg::S_IDLE;
      end
      default: state_next = frq_pkg::S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall = 1'b1;
    case (state)
      frq_pkg::S_IDLE: in_stall = 1'b0;
      frq_pkg::S_EXEC: in_stall = 1'b1;
      default:         in_stall = 1'b1;
    endcase
  end

  // operation evaluation and memory write-back
  always_comb begin
    head_next     = head;
    tail_next     = tail;
    empty_next    = empty;
    any_sent_next = any_sent;
    res_status    = frq_pkg::ST_FAIL;
    res_frame     = '0;
    res_size      = '0;
    send_slot     = empty ? '0 : frq_pkg::wrap_inc(tail);

    cnt_req       = '0;
    frm_req       = '0;
    // reads are issued at the input transfer: count at head or tail, frame at head
    cnt_req.re    = in_xfer;
    cnt_req.raddr = (operation == frq_pkg::OP_REPEAT) ? tail : head;
    frm_req.re    = in_xfer;
    frm_req.raddr = head;
    frm_req.wdata = word_q & mask;

    if (exec_go) begin
      case (op_q)
        frq_pkg::OP_SEND: begin
          if (bytes_q <= frq_pkg::BYTES_W'(cfg_size)) begin
            if (!empty && head == send_slot) begin
              res_status = frq_pkg::ST_FULL;
            end else begin
              if (empty) head_next = '0;
              frm_req.we    = 1'b1;
              frm_req.waddr = send_slot;
              cnt_req.we    = 1'b1;
              cnt_req.waddr = send_slot;
              cnt_req.wdata = frq_pkg::CNT_W'(1);
              tail_next     = send_slot;
              empty_next    = 1'b0;
              any_sent_next = 1'b1;
              res_status    = frq_pkg::ST_OK;
            end
          end
        end
        frq_pkg::OP_RECV: begin
          if (empty) begin
            res_status = frq_pkg::ST_NOFRAME;
          end else if (cnt_rd != '0) begin
            res_frame     = frm_rd & mask;
            res_size      = cfg_size;
            cnt_req.we    = 1'b1;
            cnt_req.waddr = head;
            cnt_req.wdata = cnt_rd - frq_pkg::CNT_W'(1);
            if (cnt_rd == frq_pkg::CNT_W'(1)) begin
              if (head == tail) empty_next = 1'b1;
              else              head_next  = frq_pkg::wrap_inc(head);
            end
            res_status = frq_pkg::ST_OK;
          end
        end
        frq_pkg::OP_REPEAT: begin
          if (any_sent) begin
            if (empty) begin
              head_next     = tail;
              empty_next    = 1'b0;
              cnt_req.we    = 1'b1;
              cnt_req.waddr = tail;
              cnt_req.wdata = frq_pkg::CNT_W'(1);
            end else if (cnt_rd != frq_pkg::CNT_MAX) begin
              cnt_req.we    = 1'b1;
              cnt_req.waddr = tail;
              cnt_req.wdata = cnt_rd + frq_pkg::CNT_W'(1);
            end
            res_status = frq_pkg::ST_OK;
          end
        end
        default: res_status = frq_pkg::ST_FAIL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= frq_pkg::S_IDLE;
      cfg_size  <= frq_pkg::SIZE_W'(8);
      head      <= '0;
      tail      <= '0;
      empty     <= 1'b1;
      any_sent  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      empty    <= empty_next;
      any_sent <= any_sent_next;
      if (cfg_valid && cfg_ready) cfg_size <= cfg_data;
      if (exec_go)                out_valid <= 1'b1;
      else if (!out_stall)        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_q    <= operation;
      word_q  <= frame_word;
      bytes_q <= frame_bytes;
    end
    if (exec_go) begin
      status    <= res_status;
      frame_out <= res_frame;
      size_out  <= res_size;
    end
  end

endmodule
`default_nettype wire

### src/frq_checker.sv
`default_nettype none
module frq_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [1:0]                     status,
  input wire logic [frq_pkg::FRAME_BITS-1:0] frame_out,
  input wire logic [frq_pkg::SIZE_W-1:0]     size_out
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(frame_out)
      && $stable(size_out))
    else $error("result changed while stalled");

  // only a successful receive carries a frame or a size
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != frq_pkg::ST_OK |-> frame_out == '0 && size_out == '0)
    else $error("non-success result carries data");

  // one item at a time: the cycle after an input transfer is stalled
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind frame_ring_queue_with_repeat_top frq_checker u_frq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .frame_out (frame_out),
  .size_out  (size_out)
);
`default_nettype wire
